// ===== hdl/esd_pkg.sv =====
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types, character codes and helper functions for the escape decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

    // character codes
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X         = 8'h78;
    localparam logic [7:0] CHAR_U         = 8'h75;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BS_AT_END = 2'd1,
        STATUS_TRUNC_HEX = 2'd2,
        STATUS_TRUNC_UNI = 2'd3
    } status_t;

    // one result item
    typedef struct packed {
        logic [15:0] out_value;
        logic        is_code_point;
        status_t     status;
        logic        run_last;
        logic        string_end;
    } result_t;

    // hex digit value, non-hex characters count as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h41 + 8'd10);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h61 + 8'd10);
        end
        return v;
    endfunction

    // simple escape map: bit 8 flags a hit, bits 7:0 carry the byte
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h61:   r = {1'b1, 8'h07};
            8'h62:   r = {1'b1, 8'h08};
            8'h65:   r = {1'b1, 8'h1B};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            8'h76:   r = {1'b1, 8'h0B};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h27:   r = {1'b1, 8'h27};
            8'h22:   r = {1'b1, 8'h22};
            8'h3F:   r = {1'b1, 8'h3F};
            default: r = {1'b0, 8'h00};
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/esd_if.sv =====
// ----------------------------------------------------------------------------
// esd_if
// Valid/ready channels for escaped input bytes and decoded results.
// ----------------------------------------------------------------------------
interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface esd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_value;
    logic        is_code_point;
    logic [1:0]  status;
    logic        run_last;
    logic        string_end;

    modport source (output valid, output out_value, output is_code_point,
                    output status, output run_last, output string_end, input ready);
    modport sink   (input valid, input out_value, input is_code_point,
                    input status, input run_last, input string_end, output ready);
endinterface

// ===== hdl/escape_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Decodes a C-style escaped byte stream into bytes and 16-bit code points.
// ----------------------------------------------------------------------------
// A result is registered and valid in the cycle after its input byte is
// accepted. Throughput: one byte per cycle while the output accepts; a byte
// that yields two results (unknown escape) holds the input off while the
// second result waits in the holding register behind the output register.
// Reset: decoder returns to text mode with an empty accumulator and no
// result pending.
module escape_sequence_decoder
    import esd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    esd_in_if.sink    in_ch,
    esd_out_if.source out_ch
);

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_HEX  = 2'd2,
        MODE_UNI  = 2'd3
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [1:0]  digits_reg, digits_next;
    logic [15:0] acc_reg, acc_next;

    logic        out_valid_reg, out_valid_next;
    logic        pend_valid_reg, pend_valid_next;
    result_t     out_reg, pend_reg;

    logic        in_fire;
    logic        out_fire;
    logic        end_flag;
    logic [7:0]  c;
    logic [15:0] acc_shift;
    logic [8:0]  simple;
    logic [1:0]  n_res;
    result_t     r0, r1;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_valid_reg && out_ch.ready;
    assign c        = in_ch.in_byte;
    assign end_flag = in_ch.end_of_input;

    // accept while no second result waits and the output slot frees up
    assign in_ch.ready = !pend_valid_reg && (!out_valid_reg || out_ch.ready);

    assign acc_shift = {acc_reg[11:0], hex_value(c)};
    assign simple    = simple_escape(c);

    // decode one byte against the current mode
    always_comb
    begin
        mode_next   = mode_reg;
        digits_next = digits_reg;
        acc_next    = acc_reg;
        n_res       = 2'd0;
        r0          = '{out_value: 16'd0, is_code_point: 1'b0, status: STATUS_OK,
                        run_last: 1'b1, string_end: end_flag};
        r1          = r0;
        case (mode_reg)
            MODE_TEXT:
            begin
                if (c == CHAR_BACKSLASH) begin
                    if (end_flag) begin
                        n_res     = 2'd1;
                        r0.status = STATUS_BS_AT_END;
                    end
                    else begin
                        mode_next = MODE_ESC;
                    end
                end
                else begin
                    n_res        = 2'd1;
                    r0.out_value = {8'd0, c};
                end
            end
            MODE_ESC:
            begin
                if (simple[8]) begin
                    n_res        = 2'd1;
                    r0.out_value = {8'd0, simple[7:0]};
                    mode_next    = MODE_TEXT;
                end
                else if (c == CHAR_X) begin
                    if (end_flag) begin
                        n_res     = 2'd1;
                        r0.status = STATUS_TRUNC_HEX;
                    end
                    else begin
                        mode_next   = MODE_HEX;
                        digits_next = 2'd0;
                        acc_next    = 16'd0;
                    end
                end
                else if (c == CHAR_U) begin
                    if (end_flag) begin
                        n_res     = 2'd1;
                        r0.status = STATUS_TRUNC_UNI;
                    end
                    else begin
                        mode_next   = MODE_UNI;
                        digits_next = 2'd0;
                        acc_next    = 16'd0;
                    end
                end
                else begin
                    // unknown escape: backslash, then the character
                    n_res         = 2'd2;
                    r0.out_value  = {8'd0, CHAR_BACKSLASH};
                    r0.run_last   = 1'b0;
                    r0.string_end = 1'b0;
                    r1.out_value  = {8'd0, c};
                    mode_next     = MODE_TEXT;
                end
            end
            MODE_HEX:
            begin
                acc_next = acc_shift;
                if (digits_reg == 2'd0 && !end_flag) begin
                    digits_next = 2'd1;
                end
                else begin
                    n_res        = 2'd1;
                    r0.out_value = {8'd0, acc_shift[7:0]};
                    mode_next    = MODE_TEXT;
                end
            end
            MODE_UNI:
            begin
                acc_next = acc_shift;
                if (digits_reg == 2'd3) begin
                    n_res            = 2'd1;
                    r0.out_value     = acc_shift;
                    r0.is_code_point = 1'b1;
                    mode_next        = MODE_TEXT;
                end
                else if (end_flag) begin
                    n_res     = 2'd1;
                    r0.status = STATUS_TRUNC_UNI;
                end
                else begin
                    digits_next = digits_reg + 2'd1;
                end
            end
            default:
            begin
                mode_next = MODE_TEXT;
            end
        endcase

        // end of string or return to text clears the escape state
        if (end_flag) begin
            mode_next   = MODE_TEXT;
            digits_next = 2'd0;
            acc_next    = 16'd0;
        end
        else if (mode_next == MODE_TEXT) begin
            digits_next = 2'd0;
            acc_next    = 16'd0;
        end
    end

    // output and holding register valid flags
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        if (in_fire) begin
            out_valid_next  = (n_res != 2'd0);
            pend_valid_next = (n_res == 2'd2);
        end
        else if (out_fire) begin
            out_valid_next  = pend_valid_reg;
            pend_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= MODE_TEXT;
            digits_reg     <= 2'd0;
            acc_reg        <= 16'd0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else begin
            if (in_fire) begin
                mode_reg   <= mode_next;
                digits_reg <= digits_next;
                acc_reg    <= acc_next;
            end
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            out_reg  <= r0;
            pend_reg <= r1;
        end
        else if (out_fire) begin
            out_reg <= pend_reg;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_value     = out_reg.out_value;
    assign out_ch.is_code_point = out_reg.is_code_point;
    assign out_ch.status        = out_reg.status;
    assign out_ch.run_last      = out_reg.run_last;
    assign out_ch.string_end    = out_reg.string_end;

    // a held second result always sits behind a valid first one
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("holding register valid with empty output register");

    // the first of two results never closes its transaction
    a_pend_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (!out_reg.run_last && pend_reg.run_last))
        else $error("run_last misplaced across a two-result byte");

    // an end-of-string byte leaves the decoder in its reset state
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && end_flag) |=> (mode_reg == MODE_TEXT && digits_reg == 2'd0
                                   && acc_reg == 16'd0))
        else $error("decoder state not cleared after end of string");

    // a two-result byte stalls the input for the following cycle
    a_two_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && n_res == 2'd2) |=> !in_ch.ready)
        else $error("input accepted while a second result is pending");

endmodule

// ===== dv/escape_sequence_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_sequence_decoder_tb
// Streams escaped strings into the decoder and checks every decoded result
// against an in-bench decoder model. Both channels idle at random, and the
// result side holds off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_tb;
    import esd_pkg::*;

    // decoder modes of the in-bench model
    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_HEX  = 2'd2,
        MODE_UNI  = 2'd3
    } dec_mode_t;

    // one pending input byte
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } char_item_t;

    localparam int STREAM_BYTES = 1250;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AFTER   = 400;
    localparam int DRAIN_CYCLES = 10;
    localparam string HEX_CHARS    = "0123456789abcdefABCDEF";
    localparam string SIMPLE_CHARS = "abefnrtv\\'\"?";

    logic clk = 1'b0;
    logic rst_n;

    esd_in_if  in_ch ();
    esd_out_if out_ch ();

    escape_sequence_decoder u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    char_item_t pending_bytes[$];
    result_t    decoded_q[$];
    int         errors = 0;
    int         cycle_no = 0;
    int         results_seen = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    // model state
    dec_mode_t   mode = MODE_TEXT;
    logic [1:0]  digit_cnt = 2'd0;
    logic [15:0] acc = 16'd0;

    always #1 clk = ~clk;

    // free-running cycle count, drives the idle-free window
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
    end

    // random idle with a chance of 27 in a hundred, none inside the steady window
    function automatic bit take_break();
        if (cycle_no >= 300 && cycle_no < 700)
        begin
            return 1'b0;
        end
        return $urandom_range(99) < 27;
    endfunction

    // simple escape lookup: bit 8 flags a hit
    function automatic logic [8:0] escape_lookup(input logic [7:0] c);
        case (c)
            8'h61:   return {1'b1, 8'h07};
            8'h62:   return {1'b1, 8'h08};
            8'h65:   return {1'b1, 8'h1B};
            8'h66:   return {1'b1, 8'h0C};
            8'h6E:   return {1'b1, 8'h0A};
            8'h72:   return {1'b1, 8'h0D};
            8'h74:   return {1'b1, 8'h09};
            8'h76:   return {1'b1, 8'h0B};
            8'h5C:   return {1'b1, 8'h5C};
            8'h27:   return {1'b1, 8'h27};
            8'h22:   return {1'b1, 8'h22};
            8'h3F:   return {1'b1, 8'h3F};
            default: return 9'd0;
        endcase
    endfunction

    // hex digit value, anything else is zero
    function automatic logic [3:0] digit_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return 4'(c - 8'h30);
        end
        if (c >= "A" && c <= "F")
        begin
            return 4'(c - 8'h41 + 8'd10);
        end
        if (c >= "a" && c <= "f")
        begin
            return 4'(c - 8'h61 + 8'd10);
        end
        return 4'd0;
    endfunction

    task automatic add_result(input logic [15:0] value, input logic cp, input status_t st,
                              input logic last, input logic send);
        result_t r;
        r.out_value     = value;
        r.is_code_point = cp;
        r.status        = st;
        r.run_last      = last;
        r.string_end    = send;
        decoded_q.push_back(r);
    endtask

    // decode one accepted byte and queue the results it produces
    task automatic decode_char(input logic [7:0] c, input logic eoi);
        logic [8:0] hit;
        hit = escape_lookup(c);
        case (mode)
            MODE_TEXT:
            begin
                if (c == CHAR_BACKSLASH)
                begin
                    if (eoi)
                    begin
                        add_result(16'd0, 1'b0, STATUS_BS_AT_END, 1'b1, 1'b1);
                    end
                    else
                    begin
                        mode = MODE_ESC;
                    end
                end
                else
                begin
                    add_result({8'd0, c}, 1'b0, STATUS_OK, 1'b1, eoi);
                end
            end
            MODE_ESC:
            begin
                if (hit[8])
                begin
                    add_result({8'd0, hit[7:0]}, 1'b0, STATUS_OK, 1'b1, eoi);
                    mode = MODE_TEXT;
                end
                else if (c == CHAR_X || c == CHAR_U)
                begin
                    if (eoi)
                    begin
                        add_result(16'd0, 1'b0,
                                   status_t'((c == CHAR_X) ? STATUS_TRUNC_HEX
                                                           : STATUS_TRUNC_UNI),
                                   1'b1, 1'b1);
                    end
                    else
                    begin
                        mode      = dec_mode_t'((c == CHAR_X) ? MODE_HEX : MODE_UNI);
                        digit_cnt = 2'd0;
                        acc       = 16'd0;
                    end
                end
                else
                begin
                    // unknown escape gives the backslash and then the char
                    add_result({8'd0, CHAR_BACKSLASH}, 1'b0, STATUS_OK, 1'b0, 1'b0);
                    add_result({8'd0, c}, 1'b0, STATUS_OK, 1'b1, eoi);
                    mode = MODE_TEXT;
                end
            end
            MODE_HEX:
            begin
                acc = {acc[11:0], digit_nibble(c)};
                if (digit_cnt == 2'd0 && !eoi)
                begin
                    digit_cnt = 2'd1;
                end
                else
                begin
                    add_result({8'd0, acc[7:0]}, 1'b0, STATUS_OK, 1'b1, eoi);
                    mode = MODE_TEXT;
                end
            end
            default:
            begin
                acc = {acc[11:0], digit_nibble(c)};
                if (digit_cnt == 2'd3)
                begin
                    add_result(acc, 1'b1, STATUS_OK, 1'b1, eoi);
                    mode = MODE_TEXT;
                end
                else if (eoi)
                begin
                    add_result(16'd0, 1'b0, STATUS_TRUNC_UNI, 1'b1, 1'b1);
                end
                else
                begin
                    digit_cnt = digit_cnt + 2'd1;
                end
            end
        endcase
        // end of string restarts the decoder
        if (eoi)
        begin
            mode = MODE_TEXT;
        end
        if (eoi || mode == MODE_TEXT)
        begin
            digit_cnt = 2'd0;
            acc       = 16'd0;
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eoi);
        char_item_t it;
        it.in_byte      = b;
        it.end_of_input = eoi;
        pending_bytes.push_back(it);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_byte(s[i], i == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] pick_digit();
        if ($urandom_range(99) < 80)
        begin
            return HEX_CHARS[$urandom_range(HEX_CHARS.len() - 1)];
        end
        return 8'($urandom_range(255));
    endfunction

    // one random string, mostly well-formed escapes, sometimes raw noise
    task automatic queue_random_string();
        logic [7:0] bytes[$];
        logic [7:0] c;
        int         segs;
        int         ndig;
        bit         last;
        if ($urandom_range(99) < 10)
        begin
            repeat ($urandom_range(1, 8))
            begin
                push_byte(8'($urandom_range(255)), $urandom_range(99) < 20);
            end
            return;
        end
        segs = $urandom_range(1, 6);
        for (int k = 0; k < segs; k++)
        begin
            last = (k == segs - 1);
            case ($urandom_range(9))
                4:
                begin
                    bytes.push_back(CHAR_BACKSLASH);
                    bytes.push_back(SIMPLE_CHARS[$urandom_range(SIMPLE_CHARS.len() - 1)]);
                end
                5, 6:
                begin
                    bytes.push_back(CHAR_BACKSLASH);
                    if ($urandom_range(1))
                    begin
                        bytes.push_back(CHAR_X);
                        ndig = last ? $urandom_range(0, 2) : 2;
                    end
                    else
                    begin
                        bytes.push_back(CHAR_U);
                        ndig = last ? $urandom_range(0, 4) : 4;
                    end
                    repeat (ndig)
                    begin
                        bytes.push_back(pick_digit());
                    end
                end
                7:
                begin
                    do
                    begin
                        c = 8'($urandom_range(255));
                    end
                    while (escape_lookup(c) != 9'd0 || c == CHAR_X || c == CHAR_U);
                    bytes.push_back(CHAR_BACKSLASH);
                    bytes.push_back(c);
                end
                8:
                begin
                    // lone backslash at the end, else an escaped backslash
                    bytes.push_back(CHAR_BACKSLASH);
                    if (!last)
                    begin
                        bytes.push_back(CHAR_BACKSLASH);
                    end
                end
                default:
                begin
                    do
                    begin
                        c = 8'($urandom_range(255));
                    end
                    while (c == CHAR_BACKSLASH);
                    bytes.push_back(c);
                end
            endcase
        end
        foreach (bytes[i])
        begin
            push_byte(bytes[i], i == bytes.size() - 1);
        end
    endtask

    // input driver: predict on each accepted transaction, then offer the next
    always @(posedge clk or negedge rst_n)
    begin : driver
        char_item_t it;
        if (!rst_n)
        begin
            in_ch.valid        <= 1'b0;
            in_ch.in_byte      <= 8'd0;
            in_ch.end_of_input <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                decode_char(in_ch.in_byte, in_ch.end_of_input);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_bytes.size() > 0 && !take_break())
                begin
                    it = pending_bytes.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.in_byte      <= it.in_byte;
                    in_ch.end_of_input <= it.end_of_input;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random stalls and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.out_value     = out_ch.out_value;
                got.is_code_point = out_ch.is_code_point;
                got.status        = status_t'(out_ch.status);
                got.run_last      = out_ch.run_last;
                got.string_end    = out_ch.string_end;
                results_seen++;
                if (decoded_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result value=%h cp=%b st=%0d last=%b end=%b",
                             $time, got.out_value, got.is_code_point, got.status,
                             got.run_last, got.string_end);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (got.out_value !== want.out_value
                        || got.is_code_point !== want.is_code_point
                        || got.status !== want.status
                        || got.run_last !== want.run_last
                        || got.string_end !== want.string_end)
                    begin
                        errors++;
                        $display("%0t: mismatch expected value=%h cp=%b st=%0d last=%b end=%b",
                                 $time, want.out_value, want.is_code_point, want.status,
                                 want.run_last, want.string_end);
                        $display("%0t:          actual   value=%h cp=%b st=%0d last=%b end=%b",
                                 $time, got.out_value, got.is_code_point, got.status,
                                 got.run_last, got.string_end);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left    = hold_left - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done    = 1'b1;
                hold_left    = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= !take_break();
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        rst_n = 1'b0;

        // plain extremes, all simple escapes, hex and code point forms
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        queue_text("\\a\\b\\e\\f\\n\\r\\t\\v\\\\\\'\\\"\\?");
        queue_text("\\x4F");
        queue_text("\\xA");
        queue_text("\\x");
        queue_text("\\");
        queue_text("\\u20aC");
        queue_text("\\u12");
        queue_text("\\u");
        queue_text("\\q");
        queue_text("\\xzz\\uFfFf");

        while (pending_bytes.size() < STREAM_BYTES)
        begin
            queue_random_string();
        end
        // close any string the noise left open
        push_byte(8'h41, 1'b1);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() > 0 || in_ch.valid)
        begin
            @(posedge clk);
        end
        while (decoded_q.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (decoded_q.size() > 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, decoded_q.size());
        end

        if (errors == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #200000;
        $display("%0t: timeout", $time);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/esd_pkg.sv
hdl/esd_if.sv
hdl/escape_sequence_decoder.sv
dv/escape_sequence_decoder_tb.sv
